// File: rtl/byte_position_histogram_stddev_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the byte position histogram block
// Checks compile in simulation and drop out of synthesis builds.
// ----------------------------------------------------------------------------
`ifndef BYTE_POSITION_HISTOGRAM_STDDEV_MACROS_SVH
`define BYTE_POSITION_HISTOGRAM_STDDEV_MACROS_SVH

`ifndef SYNTHESIS
// Implication check, sampled on clk and disabled during reset.
`define BHSD_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bhsd implication check failed");
// Condition that must never be true.
`define BHSD_ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("bhsd forbidden condition seen");
`else
`define BHSD_ASSERT_IMPL(name, ante, cons)
`define BHSD_ASSERT_NEVER(name, cond)
`endif

`endif

// File: rtl/bhsd_pkg.sv
// ----------------------------------------------------------------------------
// Byte position histogram package
// Field widths, function codes and the queued request type.
// ----------------------------------------------------------------------------
package bhsd_pkg;

  localparam int POS_W     = 5;
  localparam int VAL_W     = 8;
  localparam int MEAN_W    = 24;
  localparam int STD_W     = 20;
  localparam int SUM_W     = 26;

  localparam logic FUNC_ADD    = 1'b0;
  localparam logic FUNC_REPORT = 1'b1;

  typedef struct packed {
    logic             func;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
  } item_t;

endpackage

// File: rtl/bhsd_div.sv
// ----------------------------------------------------------------------------
// Divide by 255
// Base-256 long division, one quotient byte per cycle by shift and add.
// ----------------------------------------------------------------------------
module bhsd_div #(
  parameter int DW = 48
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  output logic          done,
  output logic [DW-1:0] quot
);

  localparam int ND = (DW + 7) / 8;
  localparam int SW = ND * 8;
  localparam int CW = $clog2(ND + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [SW-1:0] sh_r;
  logic [7:0]    rem_r;
  logic [15:0]   cur;
  logic [15:0]   est;
  logic [7:0]    qd;
  logic [15:0]   rem_full;

  // The partial remainder stays below 255, so cur stays below 255 * 256
  // and the estimate gives floor(cur / 255) exactly.
  always_comb begin
    cur      = {rem_r, sh_r[SW-1 -: 8]};
    est      = cur + 16'd1 + {8'd0, cur[15:8]};
    qd       = est[15:8];
    rem_full = cur - {qd, 8'h00} + {8'h00, qd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= SW'(dividend);
      rem_r <= '0;
      cnt_r <= CW'(ND);
    end else if (busy_r) begin
      sh_r  <= {sh_r[SW-9:0], qd};
      rem_r <= rem_full[7:0];
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign done = done_r;
  assign quot = sh_r[DW-1:0];

endmodule

// File: rtl/bhsd_sqrt.sv
// ----------------------------------------------------------------------------
// Serial square root
// Digit-by-digit floor square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module bhsd_sqrt
  import bhsd_pkg::*;
#(
  parameter int RW = 29
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [2*RW-1:0] x,
  output logic            done,
  output logic [RW-1:0]   root
);

  localparam int REMW = RW + 3;
  localparam int CW   = $clog2(RW + 1);

  logic              busy_r;
  logic              done_r;
  logic [CW-1:0]     cnt_r;
  logic [2*RW-1:0]   xs_r;
  logic [RW-1:0]     root_r;
  logic [REMW-1:0]   rem_r;
  logic [REMW-1:0]   trial;
  logic [REMW-1:0]   cand;
  logic              ge;

  always_comb begin
    trial = {rem_r[REMW-3:0], xs_r[2*RW-1 -: 2]};
    cand  = REMW'({root_r, 2'b01});
    ge    = (trial >= cand);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xs_r   <= x;
      root_r <= '0;
      rem_r  <= '0;
      cnt_r  <= CW'(RW);
    end else if (busy_r) begin
      xs_r   <= {xs_r[2*RW-3:0], 2'b00};
      root_r <= {root_r[RW-2:0], ge};
      rem_r  <= ge ? (trial - cand) : trial;
      cnt_r  <= cnt_r - 1'b1;
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// File: rtl/bhsd_front.sv
// ----------------------------------------------------------------------------
// Request front end
// Accepts requests, drops adds to absent positions and queues the rest.
// ----------------------------------------------------------------------------
module bhsd_front
  import bhsd_pkg::*;
#(
  parameter int POSITIONS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_func,
  input  logic [POS_W-1:0] in_byte_position,
  input  logic [VAL_W-1:0] in_byte_value,
  input  logic             init_busy,
  output logic             q_valid,
  output item_t            q_item,
  input  logic             q_pop
);

  localparam int QD  = 4;
  localparam int QPW = $clog2(QD);
  localparam int QCW = $clog2(QD + 1);

  item_t          q_mem [QD];
  logic [QPW-1:0] wr_ptr_r;
  logic [QPW-1:0] rd_ptr_r;
  logic [QCW-1:0] count_r;
  logic           accept;
  logic           push;
  logic           in_range;

  assign in_range = ({2'b00, in_byte_position} < 7'(POSITIONS));
  assign in_stall = init_busy || (count_r == QCW'(QD));
  assign accept   = in_valid && !in_stall;
  assign push     = accept && ((in_func == FUNC_REPORT) || in_range);
  assign q_valid  = (count_r != '0);
  assign q_item   = q_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= '{func: in_func, pos: in_byte_position, val: in_byte_value};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, q_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// File: rtl/bhsd_back.sv
// ----------------------------------------------------------------------------
// Histogram back end
// Holds the histogram memory, runs increments and the report sequencer.
// ----------------------------------------------------------------------------
`include "byte_position_histogram_stddev_macros.svh"

module bhsd_back
  import bhsd_pkg::*;
#(
  parameter int POSITIONS  = 32,
  parameter int COUNT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  item_t             q_item,
  output logic              q_pop,
  output logic              init_busy,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [POS_W-1:0]  out_result_position,
  output logic [MEAN_W-1:0] out_mean_q8,
  output logic [STD_W-1:0]  out_std_dev_q8,
  output logic [STD_W-1:0]  out_avg_std_dev_q8,
  output logic              out_last
);

  localparam int DEPTH = POSITIONS * 256;
  localparam int AW    = $clog2(DEPTH);
  localparam int PIW   = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
  localparam int TW    = COUNT_BITS + 8;
  localparam int S2W   = 2 * COUNT_BITS + 8;
  localparam int NW    = 2 * TW;
  localparam int RW    = COUNT_BITS + 13;
  localparam int XW    = 2 * RW;
  localparam int MCW   = $clog2(TW);
  localparam int PW    = SUM_W + 33;
  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};
  // Reciprocal of POSITIONS scaled by 2^32; exact for any 26-bit sum.
  localparam logic [32:0] RECIP = 33'((64'd1 << 32) / 64'(POSITIONS) + 64'd1);

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_WALK  = 4'd2;
  localparam logic [3:0] ST_DRAIN = 4'd3;
  localparam logic [3:0] ST_MUL   = 4'd4;
  localparam logic [3:0] ST_NUM   = 4'd5;
  localparam logic [3:0] ST_DIV   = 4'd6;
  localparam logic [3:0] ST_SQRT  = 4'd7;
  localparam logic [3:0] ST_ACC   = 4'd8;
  localparam logic [3:0] ST_AVG   = 4'd9;
  localparam logic [3:0] ST_EMIT  = 4'd10;

  logic [COUNT_BITS-1:0]   mem [DEPTH];
  logic [COUNT_BITS-1:0]   rd_data_r;
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic [COUNT_BITS-1:0]   mem_wdata;
  logic [AW-1:0]           mem_raddr;

  logic [3:0]              state_r;
  logic [AW-1:0]           clr_addr_r;
  logic                    b_v_r;
  logic                    b_hit_r;
  logic [AW-1:0]           b_addr_r;
  logic [COUNT_BITS-1:0]   fwd_r;
  logic [COUNT_BITS-1:0]   cnt_old;
  logic [COUNT_BITS-1:0]   cnt_new;
  logic [AW-1:0]           item_addr;
  logic [AW-1:0]           walk_addr;
  logic                    add_pop;
  logic                    rep_pop;

  logic [PIW-1:0]          pos_r;
  logic [7:0]              bkt_r;
  logic                    rdv_r;
  logic                    sqv_r;
  logic [COUNT_BITS-1:0]   c_r;
  logic [2*COUNT_BITS-1:0] sq_r;
  logic [TW-1:0]           tot_r;
  logic [S2W-1:0]          s2_r;
  logic [NW-1:0]           acc_r;
  logic [NW-1:0]           mcd_r;
  logic [TW-1:0]           mpl_r;
  logic [MCW-1:0]          mcnt_r;
  logic [NW-1:0]           num_r;
  logic [NW-1:0]           num_nxt;
  logic [RW-1:0]           sd_r;
  logic [SUM_W-1:0]        sum_r;
  logic [SUM_W-1:0]        sum_nxt;
  logic [PW-1:0]           avg_prod_r;
  logic [STD_W-1:0]        avg_r;
  logic                    is_last;
  logic                    out_free;
  logic                    walk_start;

  logic                    out_valid_r;
  logic [POS_W-1:0]        out_pos_r;
  logic [MEAN_W-1:0]       out_mean_r;
  logic [STD_W-1:0]        out_std_r;
  logic [STD_W-1:0]        out_avg_r;
  logic                    out_last_r;

  logic                    div_start;
  logic [NW-1:0]           div_dividend;
  logic                    div_done;
  logic [NW-1:0]           div_q;
  logic                    sqrt_start;
  logic [XW-1:0]           sqrt_x;
  logic                    sqrt_done;
  logic [RW-1:0]           sqrt_root;

  assign item_addr  = AW'({q_item.pos, q_item.val});
  assign walk_addr  = AW'({pos_r, bkt_r});
  assign add_pop    = (state_r == ST_IDLE) && q_valid && (q_item.func == FUNC_ADD);
  assign rep_pop    = (state_r == ST_IDLE) && q_valid && (q_item.func == FUNC_REPORT) && !b_v_r;
  assign q_pop      = add_pop || rep_pop;
  assign init_busy  = (state_r == ST_CLEAR);
  assign is_last    = (pos_r == PIW'(POSITIONS - 1));
  assign out_free   = !out_valid_r || !out_stall;
  assign walk_start = rep_pop || ((state_r == ST_EMIT) && out_free && !is_last);
  assign sum_nxt    = sum_r + SUM_W'(sd_r);
  assign num_nxt    = (NW'(s2_r) << 8) - acc_r;

  // The write of the previous increment lands too late for this read.
  assign cnt_old = b_hit_r ? fwd_r : rd_data_r;
  assign cnt_new = (cnt_old == CMAX) ? cnt_old : cnt_old + 1'b1;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = b_addr_r;
    mem_wdata = cnt_new;
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end else if (state_r == ST_WALK) begin
      mem_we    = 1'b1;
      mem_waddr = walk_addr;
      mem_wdata = '0;
    end else if (b_v_r) begin
      mem_we    = 1'b1;
    end
    mem_raddr = (state_r == ST_WALK) ? walk_addr : item_addr;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  // num * 256 / 255 is num plus num / 255, so only the divide is serial.
  always_comb begin
    div_start    = (state_r == ST_NUM);
    div_dividend = num_nxt;
    sqrt_start   = (state_r == ST_DIV) && div_done;
    sqrt_x       = XW'(num_r) + XW'(div_q);
  end

  bhsd_div #(.DW(NW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .done     (div_done),
    .quot     (div_q)
  );

  bhsd_sqrt #(.RW(RW)) u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .x     (sqrt_x),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      b_v_r       <= 1'b0;
      rdv_r       <= 1'b0;
      sqv_r       <= 1'b0;
      out_valid_r <= 1'b0;
      sum_r       <= '0;
    end else begin
      b_v_r       <= add_pop;
      rdv_r       <= (state_r == ST_WALK);
      sqv_r       <= rdv_r;
      out_valid_r <= ((state_r == ST_EMIT) && out_free) || (out_valid_r && out_stall);
      unique case (state_r)
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == AW'(DEPTH - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (rep_pop) begin
            state_r <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (bkt_r == 8'hFF) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!rdv_r && !sqv_r) begin
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (mcnt_r == MCW'(TW - 1)) begin
            state_r <= ST_NUM;
          end
        end
        ST_NUM: state_r <= ST_DIV;
        ST_DIV: begin
          if (div_done) begin
            state_r <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (sqrt_done) begin
            state_r <= ST_ACC;
          end
        end
        ST_ACC: begin
          sum_r   <= sum_nxt;
          state_r <= is_last ? ST_AVG : ST_EMIT;
        end
        ST_AVG: state_r <= ST_EMIT;
        ST_EMIT: begin
          if (out_free) begin
            if (is_last) begin
              sum_r   <= '0;
              state_r <= ST_IDLE;
            end else begin
              state_r <= ST_WALK;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    b_addr_r <= item_addr;
    b_hit_r  <= b_v_r && (b_addr_r == item_addr);
    if (b_v_r) begin
      fwd_r <= cnt_new;
    end

    c_r  <= rd_data_r;
    sq_r <= rd_data_r * rd_data_r;

    if (walk_start) begin
      tot_r <= '0;
      s2_r  <= '0;
      bkt_r <= '0;
      pos_r <= rep_pop ? '0 : pos_r + 1'b1;
    end else begin
      if (sqv_r) begin
        tot_r <= tot_r + TW'(c_r);
        s2_r  <= s2_r + S2W'(sq_r);
      end
      if (state_r == ST_WALK) begin
        bkt_r <= bkt_r + 1'b1;
      end
    end

    if (state_r == ST_DRAIN) begin
      acc_r  <= '0;
      mcd_r  <= NW'(tot_r);
      mpl_r  <= tot_r;
      mcnt_r <= '0;
    end else if (state_r == ST_MUL) begin
      if (mpl_r[0]) begin
        acc_r <= acc_r + mcd_r;
      end
      mcd_r  <= {mcd_r[NW-2:0], 1'b0};
      mpl_r  <= {1'b0, mpl_r[TW-1:1]};
      mcnt_r <= mcnt_r + 1'b1;
    end

    if (state_r == ST_NUM) begin
      num_r <= num_nxt;
    end
    if ((state_r == ST_SQRT) && sqrt_done) begin
      sd_r <= sqrt_root;
    end
    if ((state_r == ST_ACC) && !is_last) begin
      avg_r <= '0;
    end
    if ((state_r == ST_ACC) && is_last) begin
      avg_prod_r <= PW'(sum_nxt) * PW'(RECIP);
    end
    if (state_r == ST_AVG) begin
      avg_r <= avg_prod_r[32 +: STD_W];
    end

    if ((state_r == ST_EMIT) && out_free) begin
      out_pos_r  <= POS_W'(pos_r);
      out_mean_r <= MEAN_W'(tot_r);
      out_std_r  <= STD_W'(sd_r);
      out_avg_r  <= avg_r;
      out_last_r <= is_last;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_result_position = out_pos_r;
  assign out_mean_q8         = out_mean_r;
  assign out_std_dev_q8      = out_std_r;
  assign out_avg_std_dev_q8  = out_avg_r;
  assign out_last            = out_last_r;

  `BHSD_ASSERT_NEVER(a_no_result_in_clear, (state_r == ST_CLEAR) && out_valid_r)
  `BHSD_ASSERT_IMPL(a_walk_no_add, (state_r == ST_WALK), !b_v_r)
  `BHSD_ASSERT_IMPL(a_sqrt_done_state, sqrt_done, (state_r == ST_SQRT))
  `BHSD_ASSERT_IMPL(a_div_done_state, div_done, (state_r == ST_DIV))

endmodule

// File: rtl/byte_position_histogram_stddev.sv
// ----------------------------------------------------------------------------
// Byte position histogram with per-position standard deviation
// Counts hash bytes per (position, value) and reports their spread.
// ----------------------------------------------------------------------------
// Requests enter on the in_ channel (in_valid / in_stall). An add request
// bumps one saturating counter; adds to positions at or beyond POSITIONS
// are taken and dropped. Adds issue at one per cycle while no report runs
// and produce no result. A report request walks all positions and gives
// POSITIONS results on the out_ channel (out_valid / out_stall), position 0
// first. Each result comes from a sweep of the position's 256 buckets,
// the serial multiplier for the squared total, the byte-serial divide by
// 255 and the serial square root; the last result adds a step for the
// average, a multiply by the reciprocal. The report also zeroes the
// histogram as it reads it and clears the sum. After reset the block
// sweeps all POSITIONS*256 memory entries to zero, one entry per cycle,
// with in_stall high. A stalled receiver holds the result register;
// requests keep queuing (four deep) until the queue fills.
// ----------------------------------------------------------------------------
module byte_position_histogram_stddev
  import bhsd_pkg::*;
#(
  parameter int POSITIONS  = 32,
  parameter int COUNT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_func,
  input  logic [POS_W-1:0]  in_byte_position,
  input  logic [VAL_W-1:0]  in_byte_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [POS_W-1:0]  out_result_position,
  output logic [MEAN_W-1:0] out_mean_q8,
  output logic [STD_W-1:0]  out_std_dev_q8,
  output logic [STD_W-1:0]  out_avg_std_dev_q8,
  output logic              out_last
);

  // Queue between the front end and the back end.
  logic  q_valid;
  item_t q_item;
  logic  q_pop;
  // High while the memory is being zeroed after reset.
  logic  init_busy;

  bhsd_front #(.POSITIONS(POSITIONS)) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_byte_position (in_byte_position),
    .in_byte_value    (in_byte_value),
    .init_busy        (init_busy),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop)
  );

  bhsd_back #(.POSITIONS(POSITIONS), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_valid             (q_valid),
    .q_item              (q_item),
    .q_pop               (q_pop),
    .init_busy           (init_busy),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_result_position (out_result_position),
    .out_mean_q8         (out_mean_q8),
    .out_std_dev_q8      (out_std_dev_q8),
    .out_avg_std_dev_q8  (out_avg_std_dev_q8),
    .out_last            (out_last)
  );

endmodule
